### hw/rtl/bwra_pkg.sv
package bwra_pkg;

    localparam int MAX_HALF_WINDOW = 63;
    localparam int SAMPLE_BITS     = 16;
    localparam int LINE_DEPTH      = 2 * MAX_HALF_WINDOW + 1;
    localparam int PTR_BITS        = $clog2(LINE_DEPTH + 1);
    localparam int RAM_DEPTH       = 1 << PTR_BITS;
    localparam int HW_BITS         = 6;
    localparam int CNT_BITS        = 7;
    localparam int FRAC_BITS       = 11;
    localparam int SQ_BITS         = 2 * SAMPLE_BITS;
    localparam int SUM_BITS        = 38;
    localparam int MAG_BITS        = SAMPLE_BITS + 1;
    localparam int ROOT_BITS       = 16;
    localparam int KBITS           = $clog2(ROOT_BITS);
    localparam int ASQ_BITS        = 2 * MAG_BITS;
    localparam int PROD_BITS       = SUM_BITS + ROOT_BITS + 1;
    localparam int LHS_BITS        = 72;
    localparam int OUT_BITS        = 16;

    localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(1);

    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic                neg;
        logic [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0] cnt;
    } gain_req_t;

    typedef enum logic [1:0] {
        G_IDLE,
        G_RHS,
        G_MUL,
        G_CMP
    } gain_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP_RD,
        S_DROP_SQ,
        S_DROP_SUB,
        S_WRITE,
        S_ADD,
        S_EMIT_RD,
        S_EMIT_GO,
        S_EMIT_WAIT,
        S_FL_CHECK
    } ctl_state_t;

endpackage

### hw/rtl/box_window_rms_agc.sv
// Sliding-window RMS gain: each sample is divided by the RMS of a centered box window of
// half_window samples per side (clipped at trace ends, divisor counts samples present),
// output as saturated Q5.11. Outputs trail inputs by half_window samples; tlast on input
// flushes the rest and tlast marks the final output. A config write resets the trace.
// Each input is accepted, written and added, then each output it releases takes a RAM read
// of the sample line, a start, then a square-root/divide (a setup step, a multiply and a
// compare per bit over 16 result bits, a hand-off step); each flushed output adds a check
// step, and a zero mean square skips the bit loop of the divide. Drops of expired samples
// add a read, square and subtract step each, and a stalled output register holds the
// block until it frees. One item is processed at a time.
module box_window_rms_agc
    import bwra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HW_BITS-1:0]  cfg_data,       // half_window
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [15:0] sample
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [15:0] gained
    output logic                m_axis_tlast
);

    ctl_state_t              state_reg, state_next;
    logic [HW_BITS-1:0]      hw_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [CNT_BITS-1:0]     rcv_reg;
    logic [CNT_BITS-1:0]     wc_reg;
    logic [PTR_BITS-1:0]     newest_reg;
    logic [SAMPLE_BITS-1:0]  samp_reg;
    logic                    last_reg;
    logic [CNT_BITS-1:0]     j_reg;
    logic [HW_BITS:0]        d_reg;
    logic                    flush_reg;
    logic                    emit_last_reg;
    logic [PTR_BITS-1:0]     k_reg;
    logic [SQ_BITS-1:0]      sq_reg;
    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     out_data_reg;
    logic                    out_last_reg;

    logic                    cfg_acc, in_acc;
    logic                    ram_we, ram_re;
    logic [PTR_BITS-1:0]     waddr, raddr;
    logic [SAMPLE_BITS-1:0]  rdata;
    logic signed [SQ_BITS-1:0] sq_sel;
    logic signed [SAMPLE_BITS-1:0] sq_src;
    logic                    g_start, g_busy;
    gain_req_t               g_req;
    logic [OUT_BITS-1:0]     g_result;
    logic                    out_free, out_load;
    logic [CNT_BITS:0]       two_h1, back;
    logic                    main_emit;

    assign cfg_ready     = (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign two_h1    = {hw_reg, 1'b1} + (CNT_BITS + 1)'(0);
    assign back      = (CNT_BITS + 1)'(d_reg) + (CNT_BITS + 1)'(hw_reg) + (CNT_BITS + 1)'(1);
    assign main_emit = (j_reg >= CNT_BITS'(hw_reg));

    assign ram_we = (state_reg == S_WRITE);
    assign waddr  = newest_reg + PTR_BITS'(1);
    assign ram_re = (state_reg == S_DROP_RD) || (state_reg == S_EMIT_RD);
    assign raddr  = newest_reg - k_reg;

    bwra_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (samp_reg),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sq_src = (state_reg == S_WRITE) ? $signed(samp_reg) : $signed(rdata);
    assign sq_sel = sq_src * sq_src;

    assign g_start   = (state_reg == S_EMIT_GO);
    assign g_req.neg = rdata[SAMPLE_BITS-1];
    assign g_req.mag = rdata[SAMPLE_BITS-1] ? MAG_BITS'(-$signed({rdata[SAMPLE_BITS-1], rdata}))
                                             : MAG_BITS'(rdata);
    assign g_req.sum = sum_reg;
    assign g_req.cnt = wc_reg;

    bwra_gain u_gain (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (g_start),
        .req    (g_req),
        .busy   (g_busy),
        .result (g_result)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == S_EMIT_WAIT) && !g_busy && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ((CNT_BITS + 1)'(rcv_reg) >= two_h1) ? S_DROP_RD : S_WRITE;
                end
            end
            S_DROP_RD:  state_next = S_DROP_SQ;
            S_DROP_SQ:  state_next = S_DROP_SUB;
            S_DROP_SUB: state_next = flush_reg ? S_EMIT_RD : S_WRITE;
            S_WRITE:    state_next = S_ADD;
            S_ADD:
            begin
                if (main_emit)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (last_reg)
                begin
                    state_next = S_FL_CHECK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD:  state_next = S_EMIT_GO;
            S_EMIT_GO:  state_next = S_EMIT_WAIT;
            S_EMIT_WAIT:
            begin
                if (out_load)
                begin
                    if (emit_last_reg || !last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FL_CHECK;
                    end
                end
            end
            S_FL_CHECK:
            begin
                if ((CNT_BITS + 1)'(j_reg) >= back && back < (CNT_BITS + 1)'(LINE_DEPTH))
                begin
                    state_next = S_DROP_RD;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hw_reg        <= HW_RESET;
            sum_reg       <= '0;
            rcv_reg       <= '0;
            wc_reg        <= '0;
            newest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                hw_reg  <= cfg_data;
                sum_reg <= '0;
                rcv_reg <= '0;
                wc_reg  <= '0;
            end
            case (state_reg)
                S_DROP_SUB:
                begin
                    sum_reg <= (sum_reg >= SUM_BITS'(sq_reg)) ? sum_reg - SUM_BITS'(sq_reg) : '0;
                    if (wc_reg != '0)
                    begin
                        wc_reg <= wc_reg - CNT_BITS'(1);
                    end
                end
                S_WRITE:
                begin
                    newest_reg <= waddr;
                end
                S_ADD:
                begin
                    sum_reg <= sum_reg + SUM_BITS'(sq_reg);
                    if (wc_reg < CNT_BITS'(LINE_DEPTH))
                    begin
                        wc_reg <= wc_reg + CNT_BITS'(1);
                    end
                    if (!main_emit && !last_reg)
                    begin
                        rcv_reg <= (j_reg < CNT_BITS'(LINE_DEPTH - 1)) ? j_reg + CNT_BITS'(1)
                                                                       : CNT_BITS'(LINE_DEPTH);
                    end
                end
                S_EMIT_WAIT:
                begin
                    if (out_load && !last_reg)
                    begin
                        rcv_reg <= (j_reg < CNT_BITS'(LINE_DEPTH - 1)) ? j_reg + CNT_BITS'(1)
                                                                       : CNT_BITS'(LINE_DEPTH);
                    end
                    else if (out_load && emit_last_reg)
                    begin
                        sum_reg <= '0;
                        rcv_reg <= '0;
                        wc_reg  <= '0;
                    end
                end
                default:
                begin
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= g_result;
            out_last_reg <= emit_last_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    samp_reg  <= s_axis_tdata[SAMPLE_BITS-1:0];
                    last_reg  <= s_axis_tlast;
                    j_reg     <= rcv_reg;
                    k_reg     <= PTR_BITS'({hw_reg, 1'b0});
                    flush_reg <= 1'b0;
                end
            end
            S_DROP_SQ:
            begin
                sq_reg <= SQ_BITS'(sq_sel);
            end
            S_DROP_SUB:
            begin
                if (flush_reg)
                begin
                    k_reg         <= PTR_BITS'(d_reg);
                    emit_last_reg <= (d_reg == '0);
                end
            end
            S_WRITE:
            begin
                sq_reg <= SQ_BITS'(sq_sel);
            end
            S_ADD:
            begin
                k_reg         <= PTR_BITS'(hw_reg);
                emit_last_reg <= last_reg && (hw_reg == '0);
                flush_reg     <= 1'b0;
                // first flush position: one before the center just emitted, or all seen
                d_reg         <= main_emit ? (HW_BITS + 1)'(hw_reg) - (HW_BITS + 1)'(1)
                                           : (HW_BITS + 1)'(j_reg);
            end
            S_EMIT_WAIT:
            begin
                if (out_load && flush_reg)
                begin
                    d_reg <= d_reg - (HW_BITS + 1)'(1);
                end
            end
            S_FL_CHECK:
            begin
                flush_reg <= 1'b1;
                if ((CNT_BITS + 1)'(j_reg) >= back && back < (CNT_BITS + 1)'(LINE_DEPTH))
                begin
                    k_reg <= PTR_BITS'(back);
                end
                else
                begin
                    k_reg         <= PTR_BITS'(d_reg);
                    emit_last_reg <= (d_reg == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### hw/rtl/bwra_ram.sv
module bwra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/bwra_gain.sv
module bwra_gain
    import bwra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gain_req_t           req,
    output logic                busy,
    output logic [OUT_BITS-1:0] result
);

    gain_state_t                 state_reg, state_next;
    gain_req_t                   req_reg;
    logic [ASQ_BITS-1:0]         asq_reg;
    logic [LHS_BITS-1:0]         rhs_reg;
    logic [LHS_BITS-1:0]         m2s_reg;
    logic [PROD_BITS-1:0]        prod_reg;
    logic [ROOT_BITS-1:0]        m_reg;
    logic [KBITS-1:0]            k_reg;
    logic [OUT_BITS-1:0]         result_reg;

    logic [ROOT_BITS-1:0]        bitv;
    logic [ROOT_BITS:0]          trial;
    logic [ASQ_BITS+CNT_BITS-1:0] an;
    logic [LHS_BITS-1:0]         cand;
    logic                        take;
    logic [ROOT_BITS-1:0]        m_fin;

    assign bitv  = ROOT_BITS'(1) << k_reg;
    // (m + bit)^2 - m^2 = (2m + bit) * bit
    assign trial = {m_reg, 1'b0} | {1'b0, bitv};
    assign an    = asq_reg * req_reg.cnt;
    assign cand  = m2s_reg + (LHS_BITS'(prod_reg) << k_reg);
    assign take  = (cand <= rhs_reg);
    assign m_fin = take ? (m_reg | bitv) : m_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    state_next = G_RHS;
                end
            end
            G_RHS:
            begin
                if (req_reg.sum == '0 || req_reg.cnt == '0)
                begin
                    state_next = G_IDLE;
                end
                else
                begin
                    state_next = G_MUL;
                end
            end
            G_MUL:
            begin
                state_next = G_CMP;
            end
            G_CMP:
            begin
                state_next = (k_reg == '0) ? G_IDLE : G_MUL;
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    req_reg <= req;
                    asq_reg <= req.mag * req.mag;
                end
            end
            G_RHS:
            begin
                rhs_reg <= LHS_BITS'(an) << (2 * FRAC_BITS);
                m2s_reg <= '0;
                m_reg   <= '0;
                k_reg   <= KBITS'(ROOT_BITS - 1);
                if (req_reg.sum == '0 || req_reg.cnt == '0)
                begin
                    result_reg <= '0;
                end
            end
            G_MUL:
            begin
                prod_reg <= req_reg.sum * trial;
            end
            G_CMP:
            begin
                if (take)
                begin
                    m_reg   <= m_fin;
                    m2s_reg <= cand;
                end
                k_reg <= k_reg - KBITS'(1);
                if (k_reg == '0)
                begin
                    if (req_reg.neg)
                    begin
                        if (m_fin > ROOT_BITS'(32768))
                        begin
                            result_reg <= OUT_BITS'(32768);
                        end
                        else
                        begin
                            result_reg <= OUT_BITS'(-m_fin);
                        end
                    end
                    else if (m_fin > ROOT_BITS'(32767))
                    begin
                        result_reg <= OUT_BITS'(32767);
                    end
                    else
                    begin
                        result_reg <= m_fin;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != G_IDLE);
    assign result = result_reg;

endmodule

### hw/rtl/bwra_chk.sv
module bwra_chk
    import bwra_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [15:0]        m_axis_tdata,
    input logic               m_axis_tlast
);

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // an accepted sample leaves the block busy in the following cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready)
        else $error("block ready right after input transaction");

    // a config write leaves the block idle
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> cfg_ready)
        else $error("config write left the block busy");

    // input and config are never taken together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tvalid && s_axis_tready && cfg_valid && cfg_ready))
        else $error("input and config transactions in the same cycle");

endmodule

bind box_window_rms_agc bwra_chk u_bwra_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### dv/box_window_rms_agc_test.sv
module box_window_rms_agc_test;
    import bwra_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_GAP  = 200;

    typedef struct {
        logic [15:0] gained;
        logic        eot;
    } gain_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [HW_BITS-1:0]  cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                m_axis_tlast;

    // predictor state
    logic signed [15:0]  line_q [LINE_DEPTH];
    logic [63:0]         sq_sum;
    int                  rx_count;
    int                  win_count;
    int                  half_win;

    gain_out_t           gain_q [$];
    int                  errors = 0;
    int                  send_idle = 0;
    int                  recv_stall = 0;
    int                  hold_cycles = 0;
    int                  quiet_cycles = 0;

    box_window_rms_agc i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_trace();
        foreach (line_q[k]) line_q[k] = '0;
        sq_sum    = '0;
        rx_count  = 0;
        win_count = 0;
    endfunction

    function automatic logic [63:0] mag_of(logic signed [15:0] s);
        logic signed [63:0] w;
        w = s;
        return (w < 0) ? -w : w;
    endfunction

    function automatic void drop_square(logic signed [15:0] s);
        logic [63:0] q;
        q = mag_of(s) * mag_of(s);
        sq_sum = (sq_sum >= q) ? sq_sum - q : '0;
        if (win_count > 0)
            win_count--;
    endfunction

    // largest m with m*m*S <= a*a*n*2^22, then saturate
    function automatic logic [15:0] rms_gain(logic signed [15:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [31:0]  m;
        logic [31:0]  t;
        if (sq_sum == 0 || win_count == 0)
            return '0;
        rhs = (128'(mag_of(s) * mag_of(s)) * 128'(win_count)) << (2 * FRAC_BITS);
        m = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = m | (32'd1 << b);
            lhs = 128'(t) * 128'(t) * 128'(sq_sum);
            if (lhs <= rhs)
                m = t;
        end
        if (s < 0)
        begin
            if (m > 32768)
                m = 32768;
            return 16'(-m);
        end
        if (m > 32767)
            m = 32767;
        return m[15:0];
    endfunction

    function automatic void push_gain(logic signed [15:0] s);
        gain_out_t g;
        g.gained = rms_gain(s);
        g.eot    = 1'b0;
        gain_q.push_back(g);
    endfunction

    function automatic void predict_sample(logic signed [15:0] s, logic lst);
        int h;
        int j;
        int d;
        int back;
        int n;
        h = half_win;
        j = rx_count;
        n = 0;
        if (j >= 2 * h + 1)
            drop_square(line_q[2 * h]);
        for (int k = LINE_DEPTH - 1; k > 0; k--)
            line_q[k] = line_q[k - 1];
        line_q[0] = s;
        sq_sum += mag_of(s) * mag_of(s);
        if (win_count < LINE_DEPTH)
            win_count++;
        if (j >= h)
        begin
            push_gain(line_q[h]);
            n++;
        end
        if (lst)
        begin
            d = (j >= h) ? h - 1 : j;
            for (; d >= 0; d--)
            begin
                back = d + h + 1;
                if (j >= back && back < LINE_DEPTH)
                    drop_square(line_q[back]);
                push_gain(line_q[d]);
                n++;
            end
            if (n > 0)
                gain_q[gain_q.size() - 1].eot = 1'b1;
            clear_trace();
        end
        else
            rx_count = (j + 1 < LINE_DEPTH) ? j + 1 : LINE_DEPTH;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        gain_out_t g;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (gain_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output gained=%h last=%b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                g = gain_q.pop_front();
                if (m_axis_tdata !== g.gained || m_axis_tlast !== g.eot)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: gained exp %h got %h, last exp %b got %b",
                                 g.gained, m_axis_tdata, g.eot, m_axis_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] s, input logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_sample(s, lst);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        while (gain_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_half_window(input int v);
        end_burst();
        cfg_valid <= 1'b1;
        cfg_data  <= HW_BITS'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        half_win = (v > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : v;
        clear_trace();
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(16) - 8);
            1:       return 16'h0000;
            2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] v [6] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h1234};
        write_half_window(1);
        foreach (v[k])
            send_sample(v[k], k == 5);
        // all-zero trace: zero mean square
        for (int k = 0; k < 3; k++)
            send_sample(16'h0000, k == 2);
        write_half_window(0);
        for (int k = 0; k < 3; k++)
            send_sample(v[k], k == 2);
        // short trace, ends before half_window samples
        write_half_window(5);
        for (int k = 0; k < 3; k++)
            send_sample(v[k + 3], k == 2);
        send_sample(16'h8000, 1'b1);
        // partial trace abandoned by a register write
        write_half_window(4);
        for (int k = 0; k < 3; k++)
            send_sample(16'h4000, 1'b0);
        write_half_window(63);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0003, 1'b1);
        end_burst();
    endtask

    task automatic test_random(input int hw, input int idle, input int stall, input int items);
        int left;
        int len;
        send_idle  = idle;
        recv_stall = stall;
        write_half_window(hw);
        left = items;
        while (left > 0)
        begin
            if ($urandom_range(4) == 0)
                len = $urandom_range(hw + 1, 1);
            else
                len = $urandom_range(2 * hw + 8, hw + 1);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                send_sample(rand_sample(), k == len - 1);
            left -= len;
        end
        end_burst();
    endtask

    task automatic test_pressure();
        send_idle  = 0;
        recv_stall = 0;
        write_half_window(2);
        hold_cycles = 400;
        for (int k = 0; k < 40; k++)
            send_sample(rand_sample(), k == 39);
        end_burst();
    endtask

    initial
    begin
        clear_trace();
        half_win = HW_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(3, 0, 0, 40);
        test_random(63, 79, 0, 50);
        test_random(0, 0, 79, 30);
        test_random($urandom_range(20, 1), 16, 16, 40);
        test_pressure();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
